@@ hdl/msep_pkg.sv @@
// shared types, constants and helpers for the midi stream event parser
// no dependencies; imported by every other file except msep_if
`timescale 1ns / 1ps

package msep_pkg;

  // held note counter width and its saturation point
  localparam int NOTE_COUNT_BITS = 8;
  localparam logic [NOTE_COUNT_BITS-1:0] NOTE_COUNT_MAX = '1;

  // queue between classifier and event unit
  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  // configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 8;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_MIDI_CHANNEL = 2'd0,
    CFG_CLOCK_WRAP   = 2'd1,
    CFG_CLOCK_OFF    = 2'd2
  } cfg_reg_t;

  localparam logic [7:0] CLOCK_WRAP_RESET = 8'd23;
  localparam logic [7:0] CLOCK_OFF_RESET  = 8'd11;

  // status byte values
  localparam logic [7:0] BYTE_REALTIME_FIRST = 8'hF8;
  localparam logic [7:0] BYTE_COMMON_FIRST   = 8'hF0;
  localparam logic [7:0] BYTE_CLOCK          = 8'hF8;
  localparam logic [7:0] BYTE_START          = 8'hFA;
  localparam logic [7:0] BYTE_CONTINUE       = 8'hFB;
  localparam logic [7:0] BYTE_STOP           = 8'hFC;

  // voice message kinds (upper nibble of status)
  localparam logic [3:0] KIND_NOTE_OFF      = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON       = 4'h9;
  localparam logic [3:0] KIND_POLY_PRESSURE = 4'hA;
  localparam logic [3:0] KIND_CONTROL       = 4'hB;
  localparam logic [3:0] KIND_PROGRAM       = 4'hC;
  localparam logic [3:0] KIND_CHAN_PRESSURE = 4'hD;
  localparam logic [3:0] KIND_PITCH_BEND    = 4'hE;

  // class of a received byte, decided by the front end
  typedef enum logic [2:0] {
    BC_IGNORE = 3'd0,
    BC_START  = 3'd1,
    BC_STOP   = 3'd2,
    BC_CLOCK  = 3'd3,
    BC_VOICE  = 3'd4,
    BC_COMMON = 3'd5,
    BC_DATA   = 3'd6
  } byte_class_t;

  typedef struct packed {
    byte_class_t cls;
    logic [7:0]  value;
  } midi_item_t;

  // queue write side and read side
  typedef struct packed {
    logic       valid;
    midi_item_t item;
  } queue_port_t;

  // configuration write bundle
  typedef struct packed {
    logic                      we;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;
  } cfg_write_t;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_NOTE_ON    = 3'd1,
    EV_NOTE_OFF   = 3'd2,
    EV_BEND       = 3'd3,
    EV_CONTROL    = 3'd4,
    EV_AFTERTOUCH = 3'd5
  } event_kind_t;

  // message kinds that carry two data bytes
  function automatic logic takes_two(input logic [3:0] kind);
    logic res;
    res = (kind == KIND_NOTE_OFF) || (kind == KIND_NOTE_ON) ||
          (kind == KIND_POLY_PRESSURE) || (kind == KIND_CONTROL) ||
          (kind == KIND_PITCH_BEND);
    return res;
  endfunction

endpackage

@@ hdl/msep_if.sv @@
// valid/ready channel interfaces for the midi stream event parser
// no dependencies
`timescale 1ns / 1ps

// received byte channel
interface msep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// event result channel
interface msep_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [6:0]  first_value;
  logic [13:0] second_value;
  logic        clock_pulse_on;
  logic        clock_pulse_off;
  logic        clock_running;
  logic        all_notes_released;

  modport source (
    output valid, output event_kind, output first_value, output second_value,
    output clock_pulse_on, output clock_pulse_off, output clock_running,
    output all_notes_released, input ready
  );
  modport sink (
    input valid, input event_kind, input first_value, input second_value,
    input clock_pulse_on, input clock_pulse_off, input clock_running,
    input all_notes_released, output ready
  );
endinterface

@@ hdl/midi_stream_event_parser.sv @@
// top level of the midi stream event parser
// depends on msep_pkg, msep_if, msep_front, msep_queue and msep_back
`timescale 1ns / 1ps

// Takes one MIDI byte per transaction on in_bus and returns exactly one result
// per byte on out_bus: an event (note on/off, pitch bend, control change,
// channel aftertouch for the configured channel), clock pulse marks, clock
// running and the all-notes-released flag. Sustained rate is one byte per
// clock cycle while out_bus.ready stays high; a byte passes the two-entry
// classifier queue, then the event unit's result register. Running status
// and counter updates are combinational and registered on the pop, so a
// stalled result only backs up the queue; the input stalls once the queue
// holds two bytes. Configuration registers must be written through
// cfg_we/cfg_index/cfg_data only while no transaction is in flight; the block
// does not enforce this. Index 3 is ignored. No clearing pass follows reset.
module midi_stream_event_parser (
  input  logic                                 clk,
  input  logic                                 rst_n,
  msep_in_if.sink                              in_bus,
  msep_out_if.source                           out_bus,
  input  logic                                 cfg_we,
  input  logic [msep_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [msep_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import msep_pkg::*;

  queue_port_t queue_wr;
  queue_port_t queue_rd;
  logic        queue_ready;
  logic        queue_pop;
  cfg_write_t  cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // byte classification
  msep_front u_front (
    .in_bus      (in_bus),
    .queue_ready (queue_ready),
    .queue_wr    (queue_wr)
  );

  // decoupling queue
  msep_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (queue_wr),
    .wr_ready (queue_ready),
    .rd       (queue_rd),
    .rd_pop   (queue_pop)
  );

  // event unit and result register
  msep_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .rd      (queue_rd),
    .rd_pop  (queue_pop),
    .out_bus (out_bus)
  );

endmodule

@@ hdl/msep_front.sv @@
// front end: accepts received bytes and classifies them for the event unit
// depends on msep_pkg and msep_if
`timescale 1ns / 1ps

module msep_front (
  msep_in_if.sink                in_bus,
  input  logic                   queue_ready,
  output msep_pkg::queue_port_t  queue_wr
);
  import msep_pkg::*;

  byte_class_t cls;

  // sort the byte into real-time, status or data
  always_comb begin
    cls = BC_IGNORE;
    if (in_bus.in_byte >= BYTE_REALTIME_FIRST) begin
      unique case (in_bus.in_byte) inside
        BYTE_START, BYTE_CONTINUE: cls = BC_START;
        BYTE_STOP:                 cls = BC_STOP;
        BYTE_CLOCK:                cls = BC_CLOCK;
        default:                   cls = BC_IGNORE;
      endcase
    end else if (in_bus.in_byte >= BYTE_COMMON_FIRST) begin
      cls = BC_COMMON;
    end else if (in_bus.in_byte[7]) begin
      cls = BC_VOICE;
    end else begin
      cls = BC_DATA;
    end
  end

  // push straight into the queue while it has room
  assign in_bus.ready        = queue_ready;
  assign queue_wr.valid      = in_bus.valid;
  assign queue_wr.item.cls   = cls;
  assign queue_wr.item.value = in_bus.in_byte;

endmodule

@@ hdl/msep_queue.sv @@
// small register queue between the classifier and the event unit
// depends on msep_pkg
`timescale 1ns / 1ps

module msep_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  msep_pkg::queue_port_t  wr,
  output logic                   wr_ready,
  output msep_pkg::queue_port_t  rd,
  input  logic                   rd_pop
);
  import msep_pkg::*;

  midi_item_t                entry_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_BITS-1:0] count_r, count_nxt;
  logic                      push;
  logic                      pop;

  assign wr_ready = (count_r != QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign push     = wr.valid && wr_ready;
  assign pop      = rd_pop && rd.valid;
  assign rd.valid = (count_r != '0);
  assign rd.item  = entry_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr.item;
    end
  end

  // fill level stays within the queue depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  // a transaction that lands in an empty queue is visible next cycle
  a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
    (push && count_r == '0) |=> rd.valid)
    else $error("pushed entry not visible");

endmodule

@@ hdl/msep_back.sv @@
// event unit: running status, note counting, clock division and result register
// depends on msep_pkg and msep_if
`timescale 1ns / 1ps

module msep_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  msep_pkg::cfg_write_t   cfg,
  input  msep_pkg::queue_port_t  rd,
  output logic                   rd_pop,
  msep_out_if.source             out_bus
);
  import msep_pkg::*;

  // configuration
  logic [3:0] chan_r;
  logic [7:0] wrap_r;
  logic [7:0] off_r;

  // parser state
  logic [7:0]                 status_r, status_nxt;
  logic [6:0]                 pend_r, pend_nxt;
  logic                       await_r, await_nxt;
  logic [NOTE_COUNT_BITS-1:0] held_r, held_nxt;
  logic [7:0]                 cnt_r, cnt_nxt;
  logic                       en_r, en_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  event_kind_t ev_r;
  logic [6:0]  first_r;
  logic [13:0] second_r;
  logic        pon_r, poff_r, run_r, released_r;

  event_kind_t ev;
  logic [6:0]  first;
  logic [13:0] second;
  logic        pon, poff;
  logic [3:0]  kind;
  logic        mine;
  logic        complete;
  logic [6:0]  d1, d2;

  assign rd_pop        = rd.valid && (!out_valid_r || out_bus.ready);
  assign kind          = status_r[7:4];
  assign mine          = (status_r[3:0] == chan_r);
  assign out_valid_nxt = rd_pop ? 1'b1 : (out_bus.ready ? 1'b0 : out_valid_r);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r <= '0;
      wrap_r <= CLOCK_WRAP_RESET;
      off_r  <= CLOCK_OFF_RESET;
    end else if (cfg.we) begin
      case (cfg.index)
        CFG_MIDI_CHANNEL: chan_r <= cfg.data[3:0];
        CFG_CLOCK_WRAP:   wrap_r <= cfg.data;
        CFG_CLOCK_OFF:    off_r  <= cfg.data;
        default:          ;
      endcase
    end
  end

  // carry out one classified transaction
  always_comb begin
    status_nxt = status_r;
    pend_nxt   = pend_r;
    await_nxt  = await_r;
    held_nxt   = held_r;
    cnt_nxt    = cnt_r;
    en_nxt     = en_r;
    ev         = EV_NONE;
    first      = '0;
    second     = '0;
    pon        = 1'b0;
    poff       = 1'b0;
    complete   = 1'b0;
    d1         = '0;
    d2         = '0;
    if (rd_pop) begin
      unique case (rd.item.cls)
        BC_START: begin
          pon     = 1'b1;
          en_nxt  = 1'b1;
          cnt_nxt = 8'd1;
        end
        BC_STOP: begin
          en_nxt = 1'b0;
          poff   = 1'b1;
        end
        BC_CLOCK: begin
          if (en_r) begin
            pon     = (cnt_r == '0);
            poff    = (cnt_r != '0) && (cnt_r == off_r);
            cnt_nxt = (cnt_r >= wrap_r) ? '0 : cnt_r + 1'b1;
          end
        end
        BC_VOICE: begin
          status_nxt = rd.item.value;
          await_nxt  = 1'b0;
          pend_nxt   = '0;
        end
        BC_COMMON: begin
          status_nxt = '0;
          await_nxt  = 1'b0;
          pend_nxt   = '0;
        end
        BC_DATA: begin
          if (status_r != '0) begin
            if (takes_two(kind)) begin
              if (!await_r) begin
                pend_nxt  = rd.item.value[6:0];
                await_nxt = 1'b1;
              end else begin
                d1        = pend_r;
                d2        = rd.item.value[6:0];
                await_nxt = 1'b0;
                complete  = 1'b1;
              end
            end else begin
              d1       = rd.item.value[6:0];
              complete = 1'b1;
            end
          end
        end
        BC_IGNORE: ;
        default:   ;
      endcase

      // voice event on the configured channel
      if (complete && mine) begin
        case (kind) inside
          KIND_NOTE_ON, KIND_NOTE_OFF: begin
            first  = d1;
            second = {7'd0, d2};
            if (kind == KIND_NOTE_ON && d2 != '0) begin
              ev = EV_NOTE_ON;
              if (held_r != NOTE_COUNT_MAX) begin
                held_nxt = held_r + 1'b1;
              end
            end else begin
              ev = EV_NOTE_OFF;
              if (held_r != '0) begin
                held_nxt = held_r - 1'b1;
              end
            end
          end
          KIND_PITCH_BEND: begin
            ev     = EV_BEND;
            second = {d2, d1};
          end
          KIND_CONTROL: begin
            ev     = EV_CONTROL;
            first  = d1;
            second = {7'd0, d2};
          end
          KIND_CHAN_PRESSURE: begin
            ev    = EV_AFTERTOUCH;
            first = d1;
          end
          default: ;
        endcase
      end
    end
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r    <= '0;
      pend_r      <= '0;
      await_r     <= 1'b0;
      held_r      <= '0;
      cnt_r       <= '0;
      en_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      status_r    <= status_nxt;
      pend_r      <= pend_nxt;
      await_r     <= await_nxt;
      held_r      <= held_nxt;
      cnt_r       <= cnt_nxt;
      en_r        <= en_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (rd_pop) begin
      ev_r       <= ev;
      first_r    <= first;
      second_r   <= second;
      pon_r      <= pon;
      poff_r     <= poff;
      run_r      <= en_nxt;
      released_r <= (held_nxt == '0);
    end
  end

  assign out_bus.valid              = out_valid_r;
  assign out_bus.event_kind         = ev_r;
  assign out_bus.first_value        = first_r;
  assign out_bus.second_value       = second_r;
  assign out_bus.clock_pulse_on     = pon_r;
  assign out_bus.clock_pulse_off    = poff_r;
  assign out_bus.clock_running      = run_r;
  assign out_bus.all_notes_released = released_r;

  // a note on always leaves at least one note held
  a_note_on_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ev_r == EV_NOTE_ON) |-> !released_r)
    else $error("note on reported with no held notes");

  // pulse on and pulse off never land on the same byte
  a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(pon_r && poff_r))
    else $error("clock pulse on and off together");

  // a rising pulse only comes from a running clock
  a_pulse_running: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && pon_r) |-> run_r)
    else $error("clock pulse on while clock stopped");

  // pitch bend packs both bytes into second value only
  a_bend_first: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ev_r == EV_BEND) |-> (first_r == '0))
    else $error("pitch bend with nonzero first value");

  // a second data byte is only awaited under a two-byte running status
  a_await_status: assert property (@(posedge clk) disable iff (!rst_n)
    await_r |-> (status_r != '0 && takes_two(status_r[7:4])))
    else $error("awaiting second byte without a two-byte status");

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for midi_stream_event_parser: directed and random byte streams
// depends on msep_pkg, msep_if and the parser rtl; predicts every result in a scoreboard class
`timescale 1ns / 1ps

module testbench;
  import msep_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 4;

  // one result transaction, field for field
  typedef struct packed {
    event_kind_t kind;
    logic [6:0]  first_value;
    logic [13:0] second_value;
    logic        pulse_on;
    logic        pulse_off;
    logic        running;
    logic        released;
  } midi_result_t;

  // running status parser state and queue of predicted results
  class midi_event_tracker;
    logic [3:0]                 channel;
    logic [7:0]                 wrap_at;
    logic [7:0]                 off_at;
    logic [7:0]                 status;
    logic [6:0]                 held_data;
    logic                       awaiting;
    logic [NOTE_COUNT_BITS-1:0] held_notes;
    logic [7:0]                 pulse_count;
    logic                       clock_on;
    midi_result_t               expected_events[$];
    int                         errors;

    function new();
      channel     = '0;
      wrap_at     = CLOCK_WRAP_RESET;
      off_at      = CLOCK_OFF_RESET;
      status      = '0;
      held_data   = '0;
      awaiting    = 1'b0;
      held_notes  = '0;
      pulse_count = '0;
      clock_on    = 1'b0;
      errors      = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [7:0] value);
      case (idx)
        CFG_MIDI_CHANNEL: channel = value[3:0];
        CFG_CLOCK_WRAP:   wrap_at = value;
        CFG_CLOCK_OFF:    off_at  = value;
        default: ;
      endcase
    endfunction

    // accepted input byte: advance the state and queue the result it causes
    function void take_byte(logic [7:0] b);
      midi_result_t r;
      logic [3:0]   kind;
      logic         complete;
      logic [6:0]   d1;
      logic [6:0]   d2;
      r        = '0;
      r.kind   = EV_NONE;
      complete = 1'b0;
      d1       = '0;
      d2       = '0;
      kind     = status[7:4];
      if (b >= BYTE_REALTIME_FIRST) begin
        // real-time bytes leave running status and pending data alone
        if (b == BYTE_START || b == BYTE_CONTINUE) begin
          r.pulse_on  = 1'b1;
          clock_on    = 1'b1;
          pulse_count = 8'd1;
        end else if (b == BYTE_STOP) begin
          clock_on    = 1'b0;
          r.pulse_off = 1'b1;
        end else if (b == BYTE_CLOCK && clock_on) begin
          if (pulse_count == 8'd0)
            r.pulse_on = 1'b1;
          else if (pulse_count == off_at)
            r.pulse_off = 1'b1;
          if (pulse_count >= wrap_at)
            pulse_count = 8'd0;
          else
            pulse_count = pulse_count + 8'd1;
        end
      end else if (b[7]) begin
        // voice status becomes running status, system common clears it
        status    = (b >= BYTE_COMMON_FIRST) ? 8'd0 : b;
        awaiting  = 1'b0;
        held_data = '0;
      end else if (status != 8'd0) begin
        if (kind == KIND_PROGRAM || kind == KIND_CHAN_PRESSURE) begin
          d1       = b[6:0];
          complete = 1'b1;
        end else if (!awaiting) begin
          held_data = b[6:0];
          awaiting  = 1'b1;
        end else begin
          d1       = held_data;
          d2       = b[6:0];
          awaiting = 1'b0;
          complete = 1'b1;
        end
        // channel is checked only once the message is whole
        if (complete && status[3:0] == channel) begin
          if (kind == KIND_NOTE_ON && d2 != 7'd0) begin
            r.kind         = EV_NOTE_ON;
            r.first_value  = d1;
            r.second_value = {7'd0, d2};
            if (held_notes != NOTE_COUNT_MAX)
              held_notes = held_notes + 1'b1;
          end else if (kind == KIND_NOTE_ON || kind == KIND_NOTE_OFF) begin
            r.kind         = EV_NOTE_OFF;
            r.first_value  = d1;
            r.second_value = {7'd0, d2};
            if (held_notes != '0)
              held_notes = held_notes - 1'b1;
          end else if (kind == KIND_PITCH_BEND) begin
            r.kind         = EV_BEND;
            r.second_value = {d2, d1};
          end else if (kind == KIND_CONTROL) begin
            r.kind         = EV_CONTROL;
            r.first_value  = d1;
            r.second_value = {7'd0, d2};
          end else if (kind == KIND_CHAN_PRESSURE) begin
            r.kind        = EV_AFTERTOUCH;
            r.first_value = d1;
          end
        end
      end
      r.running  = clock_on;
      r.released = (held_notes == '0);
      expected_events.push_back(r);
    endfunction

    // accepted result: compare with the oldest prediction
    function void match_event(midi_result_t got);
      midi_result_t exp;
      if (expected_events.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with nothing expected: kind %0d first %0d second %0d",
                   $time, got.kind, got.first_value, got.second_value);
        return;
      end
      exp = expected_events.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= 10)
          $display({"%0t: mismatch kind %0d/%0d first %0d/%0d second %0d/%0d ",
                    "on %b/%b off %b/%b run %b/%b released %b/%b (expected/actual)"},
                   $time, exp.kind, got.kind, exp.first_value, got.first_value,
                   exp.second_value, got.second_value, exp.pulse_on, got.pulse_on,
                   exp.pulse_off, got.pulse_off, exp.running, got.running,
                   exp.released, got.released);
      end
    endfunction

    function int outstanding();
      return expected_events.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  int                        cycle_count;
  int                        send_idle_pct;
  int                        recv_idle_pct;
  int                        bytes_sent;
  logic [3:0]                cur_channel;

  msep_in_if  in_ch ();
  msep_out_if out_ch ();

  midi_event_tracker tracker = new();

  midi_stream_event_parser u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_ch),
    .out_bus   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor both channels
  always @(posedge clk) begin
    midi_result_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        tracker.take_byte(in_ch.in_byte);
      if (out_ch.valid && out_ch.ready) begin
        got.kind         = event_kind_t'(out_ch.event_kind);
        got.first_value  = out_ch.first_value;
        got.second_value = out_ch.second_value;
        got.pulse_on     = out_ch.clock_pulse_on;
        got.pulse_off    = out_ch.clock_pulse_off;
        got.running      = out_ch.clock_running;
        got.released     = out_ch.all_notes_released;
        tracker.match_event(got);
      end
    end
  end

  // one byte transaction, with a random gap in front
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    bytes_sent++;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    tracker.write_reg(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending and wait for every predicted result
  task automatic drain();
    in_ch.valid <= 1'b0;
    // let the monitor note the last accepted byte first
    @(posedge clk);
    while (tracker.outstanding() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] random_realtime();
    int r;
    r = $urandom_range(15);
    if (r < 9)
      return BYTE_CLOCK;
    case (r)
      9:       return BYTE_START;
      10:      return BYTE_CONTINUE;
      11:      return BYTE_STOP;
      12:      return BYTE_REALTIME_FIRST + 8'd1;
      13:      return BYTE_REALTIME_FIRST + 8'd5;
      14:      return BYTE_REALTIME_FIRST + 8'd6;
      default: return BYTE_REALTIME_FIRST + 8'd7;
    endcase
  endfunction

  // well-formed voice message, sometimes on running status or cut short
  task automatic send_voice_message();
    logic [3:0] kind;
    logic [3:0] chan;
    logic [6:0] d2;
    kind = KIND_NOTE_OFF + 4'($urandom_range(6));
    chan = ($urandom_range(3) != 0) ? cur_channel : 4'($urandom_range(15));
    d2   = 7'($urandom_range(127));
    if (kind == KIND_NOTE_ON && $urandom_range(5) == 0)
      d2 = 7'd0;
    if ($urandom_range(9) < 7)
      send_byte({kind, chan});
    send_byte({1'b0, 7'($urandom_range(127))});
    if (kind != KIND_PROGRAM && kind != KIND_CHAN_PRESSURE && $urandom_range(11) != 0) begin
      if ($urandom_range(9) == 0)
        send_byte(random_realtime());
      send_byte({1'b0, d2});
    end
  endtask

  task automatic send_random_item();
    int r;
    r = $urandom_range(99);
    if (r < 70)
      send_voice_message();
    else if (r < 80)
      send_byte(random_realtime());
    else if (r < 85)
      send_byte(BYTE_COMMON_FIRST + 8'($urandom_range(7)));
    else if (r < 95)
      send_byte({1'b0, 7'($urandom_range(127))});
    else
      repeat ($urandom_range(1, 30)) send_byte(BYTE_CLOCK);
  endtask

  task automatic run_random(input int count);
    int stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at)
      send_random_item();
  endtask

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_MIDI_CHANNEL;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    out_ch.ready  = 1'b0;
    cycle_count   = 0;
    bytes_sent    = 0;
    cur_channel   = 4'd0;
    send_idle_pct = 6;
    recv_idle_pct = 51;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: data with no status, then every message kind on channel one
    send_byte(8'h00);
    send_byte({KIND_NOTE_ON, cur_channel});
    send_byte(8'h3C);
    send_byte(8'h7F);
    // note on with zero velocity on running status
    send_byte(8'h3C);
    send_byte(8'h00);
    // note off while nothing is held
    send_byte({KIND_NOTE_OFF, cur_channel});
    send_byte(8'h7F);
    send_byte(8'h7F);
    send_byte({KIND_PITCH_BEND, cur_channel});
    send_byte(8'h7F);
    send_byte(8'h7F);
    send_byte({KIND_CONTROL, cur_channel});
    send_byte(8'h07);
    send_byte({KIND_CHAN_PRESSURE, cur_channel});
    send_byte(8'h55);
    send_byte({KIND_PROGRAM, cur_channel});
    send_byte(8'h05);
    send_byte({KIND_POLY_PRESSURE, cur_channel});
    send_byte(8'h10);
    send_byte(8'h20);
    // other channel, clock bytes inside a pending message
    send_byte({KIND_NOTE_ON, 4'hF});
    send_byte(8'h10);
    send_byte(8'h20);
    send_byte(BYTE_START);
    send_byte({KIND_NOTE_ON, cur_channel});
    send_byte(8'h20);
    send_byte(BYTE_CLOCK);
    send_byte(8'h30);
    send_byte(BYTE_STOP);
    send_byte(BYTE_CLOCK);
    send_byte(8'hFD);
    send_byte(BYTE_COMMON_FIRST);
    send_byte(8'h40);
    send_byte(BYTE_CONTINUE);
    drain();

    // phase one: low extremes, sender mostly busy, receiver stalls often
    cur_channel = 4'hF;
    write_reg(CFG_MIDI_CHANNEL, {4'd0, cur_channel});
    write_reg(CFG_CLOCK_WRAP, 8'd1);
    write_reg(CFG_CLOCK_OFF, 8'd0);
    run_random(350);
    drain();

    // phase two: high extremes, sender gaps, receiver mostly ready
    cur_channel   = 4'($urandom_range(1, 14));
    send_idle_pct = 51;
    recv_idle_pct = 6;
    write_reg(CFG_MIDI_CHANNEL, {4'd0, cur_channel});
    write_reg(CFG_CLOCK_WRAP, 8'd255);
    write_reg(CFG_CLOCK_OFF, 8'd255);
    run_random(350);
    drain();

    // phase three: short clock period, full rate, note flood to saturate the count
    cur_channel   = 4'd0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_MIDI_CHANNEL, {4'd0, cur_channel});
    write_reg(CFG_CLOCK_WRAP, 8'd4);
    write_reg(CFG_CLOCK_OFF, 8'd2);
    send_byte({KIND_NOTE_ON, cur_channel});
    repeat (260) begin
      if ($urandom_range(19) == 0)
        send_byte(random_realtime());
      send_byte({1'b0, 7'($urandom_range(127))});
      send_byte({1'b0, 7'($urandom_range(1, 127))});
    end
    run_random(250);
    drain();

    if (tracker.errors == 0 && tracker.outstanding() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
